/* rtl/cps_pkg.sv */
// Package for the Coulomb potential direct-sum core.
// Holds the shared types, sizes and codes; depends on nothing.
package cps_pkg;

  localparam int MAX_CHARGES = 1024;
  localparam int ADDR_W      = $clog2(MAX_CHARGES);
  localparam int CNT_W       = $clog2(MAX_CHARGES + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic signed [47:0] POT_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] POT_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SPARE2 = 2'd2,
    REG_SPARE3 = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] potential;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       x;
    logic [31:0]       y;
  } store_wr_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } query_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_DIFF,
    B_SQUARE,
    B_SUM,
    B_SQRT,
    B_DIV,
    B_ACC
  } back_state_t;

endpackage

/* rtl/cps_front.sv */
// Front part: takes commands, runs clears and loads, queues queries.
// Depends on cps_pkg.
module cps_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cps_pkg::in_item_t item,
  input  logic              back_idle,
  input  logic              q_pop,
  output logic              q_valid,
  output cps_pkg::query_t   q_head,
  output cps_pkg::store_wr_t store_wr,
  output logic [cps_pkg::CNT_W-1:0] count
);
  import cps_pkg::*;

  logic              hold;
  in_item_t          held;
  query_t            queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_cnt;
  logic              mem_ready;
  logic              push;
  logic              done_hold;

  assign busy      = hold;
  assign q_valid   = (q_cnt != '0);
  assign q_head    = queue[rd_ptr];
  // Clears and loads wait until every earlier query has finished.
  assign mem_ready = (q_cnt == '0) && back_idle;
  assign push      = hold && (held.opcode == OP_QUERY) && (q_cnt != QCNT_W'(QDEPTH));

  always_comb begin
    done_hold = 1'b0;
    unique case (held.opcode)
      OP_CLEAR, OP_LOAD: done_hold = mem_ready;
      OP_QUERY:          done_hold = push;
      default:           done_hold = 1'b1;
    endcase
  end

  assign store_wr.we   = hold && (held.opcode == OP_LOAD) && mem_ready &&
                         (count < CNT_W'(MAX_CHARGES));
  assign store_wr.addr = count[ADDR_W-1:0];
  assign store_wr.x    = held.pos_x;
  assign store_wr.y    = held.pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold   <= 1'b0;
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (hold && done_hold) begin
        hold <= 1'b0;
      end else if (start && !hold) begin
        hold <= 1'b1;
      end
      if (hold && held.opcode == OP_CLEAR && mem_ready) begin
        count <= '0;
      end else if (store_wr.we) begin
        count <= count + CNT_W'(1);
      end
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      q_cnt <= q_cnt + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !hold) begin
      held <= item;
    end
    if (push) begin
      queue[wr_ptr] <= '{x: held.pos_x, y: held.pos_y};
    end
  end

endmodule

/* rtl/cps_back.sv */
// Back part: charge store and the per-charge term datapath with accumulator.
// Depends on cps_pkg.
module cps_back (
  input  logic                      clk,
  input  logic                      rst,
  input  cps_pkg::store_wr_t        store_wr,
  input  logic [cps_pkg::CNT_W-1:0] count,
  input  logic                      q_valid,
  input  cps_pkg::query_t           q_head,
  output logic                      q_pop,
  output logic                      idle,
  input  logic signed [31:0]        scale,
  input  logic [31:0]               height,
  output logic                      done,
  output cps_pkg::result_t          result
);
  import cps_pkg::*;

  logic [31:0] mem_x [MAX_CHARGES];
  logic [31:0] mem_y [MAX_CHARGES];
  logic [31:0] rd_x;
  logic [31:0] rd_y;

  back_state_t state, state_next;
  logic [CNT_W-1:0]   idx;
  query_t             pt;
  logic signed [47:0] sum;
  logic               flag;
  logic [31:0]        mag_x, mag_y;
  logic [63:0]        sq_x, sq_y, sq_h;
  logic [65:0]        r2;
  logic               zero_hit;
  logic [36:0]        rem;
  logic [33:0]        root;
  logic [5:0]         step;
  logic [47:0]        dvd;
  logic [34:0]        drem;
  logic [47:0]        quot;

  logic signed [32:0] dx, dy;
  logic [36:0]        rem_t, trial;
  logic [34:0]        drem_t;
  logic signed [49:0] term, acc;
  logic [31:0]        scale_mag;
  logic               last;

  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      mem_x[store_wr.addr] <= store_wr.x;
      mem_y[store_wr.addr] <= store_wr.y;
    end
    rd_x <= mem_x[idx[ADDR_W-1:0]];
    rd_y <= mem_y[idx[ADDR_W-1:0]];
  end

  assign dx        = {pt.x[31], pt.x} - {rd_x[31], rd_x};
  assign dy        = {pt.y[31], pt.y} - {rd_y[31], rd_y};
  assign rem_t     = {rem[34:0], r2[65:64]};
  assign trial     = {1'b0, root, 2'b01};
  assign drem_t    = {drem[33:0], dvd[47]};
  assign scale_mag = scale[31] ? 32'(-scale) : 32'(scale);
  assign last      = (idx + CNT_W'(1) == count);
  assign idle      = (state == B_IDLE);
  assign q_pop     = (state == B_IDLE) && q_valid;

  always_comb begin
    if (zero_hit) begin
      if (scale > 0) begin
        term = 50'(POT_MAX);
      end else if (scale < 0) begin
        term = 50'(POT_MIN);
      end else begin
        term = '0;
      end
    end else begin
      term = scale[31] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    end
    acc = 50'(sum) + term;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (q_valid && count != '0) state_next = B_READ;
      B_READ:   state_next = B_DIFF;
      B_DIFF:   state_next = B_SQUARE;
      B_SQUARE: state_next = B_SUM;
      B_SUM:    state_next = B_SQRT;
      B_SQRT:   if (zero_hit || step == '0) state_next = zero_hit ? B_ACC : B_DIV;
      B_DIV:    if (step == '0) state_next = B_ACC;
      B_ACC:    state_next = last ? B_IDLE : B_READ;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (q_pop && count == '0) || (state == B_ACC && last);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        pt   <= q_head;
        idx  <= '0;
        sum  <= '0;
        flag <= 1'b0;
        if (q_pop && count == '0) begin
          result <= '{potential: '0, saturated: 1'b0};
        end
      end
      B_READ: begin
      end
      B_DIFF: begin
        mag_x <= dx[32] ? 32'(-dx) : 32'(dx);
        mag_y <= dy[32] ? 32'(-dy) : 32'(dy);
      end
      B_SQUARE: begin
        sq_x <= mag_x * mag_x;
        sq_y <= mag_y * mag_y;
        sq_h <= height * height;
      end
      B_SUM: begin
        r2       <= 66'(sq_x) + 66'(sq_y) + 66'(sq_h);
        zero_hit <= (sq_x == '0) && (sq_y == '0) && (sq_h == '0);
        rem      <= '0;
        root     <= '0;
        step     <= 6'd32;
      end
      B_SQRT: begin
        if (rem_t >= trial) begin
          rem  <= rem_t - trial;
          root <= {root[32:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[32:0], 1'b0};
        end
        r2   <= {r2[63:0], 2'b00};
        step <= (step == '0) ? 6'd47 : step - 6'd1;
        dvd  <= {scale_mag, 16'h0000};
        drem <= '0;
      end
      B_DIV: begin
        if (drem_t >= {1'b0, root}) begin
          drem <= drem_t - {1'b0, root};
          quot <= {quot[46:0], 1'b1};
        end else begin
          drem <= drem_t;
          quot <= {quot[46:0], 1'b0};
        end
        dvd  <= {dvd[46:0], 1'b0};
        step <= step - 6'd1;
      end
      B_ACC: begin
        idx <= idx + CNT_W'(1);
        if (acc > 50'(POT_MAX)) begin
          sum <= POT_MAX;
          result <= '{potential: POT_MAX, saturated: 1'b1};
          flag <= 1'b1;
        end else if (acc < 50'(POT_MIN)) begin
          sum <= POT_MIN;
          result <= '{potential: POT_MIN, saturated: 1'b1};
          flag <= 1'b1;
        end else begin
          sum <= acc[47:0];
          result <= '{potential: acc[47:0], saturated: flag || zero_hit};
          flag <= flag || zero_hit;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/coulomb_potential_sum_core.sv */
// Top level of the Coulomb potential direct-sum core.
// Depends on cps_pkg, cps_front and cps_back.
//
// A command is taken when start is high and busy is low. Clear empties the
// charge store and load appends one charge (dropped when 1024 are held);
// neither gives a result. A query gives one result, shown for exactly one
// cycle with done high, which the receiver cannot stall. In a query each
// stored charge goes in turn through the single shared term datapath, whose
// 33-step square root and 48-step restoring divider run one bit per cycle;
// a zero-distance charge leaves the square root at once and skips the
// divider. Up to four queries wait in a queue while
// the datapath works. Busy is high for one cycle after every transfer and
// stays high longer only when that queue is full or when a clear or load
// waits for earlier queries to finish. Configuration writes are accepted at
// every cycle and must only be made while the core is idle.
module coulomb_potential_sum_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cps_pkg::in_item_t     item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cps_pkg::cfg_index_t   cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  done,
  output cps_pkg::result_t      result
);
  import cps_pkg::*;

  // Configuration registers.
  logic signed [31:0] potential_scale;
  logic [31:0]        plane_height;

  // Front-to-back connections.
  logic               back_idle;
  logic               q_pop;
  logic               q_valid;
  query_t             q_head;
  store_wr_t          store_wr;
  logic [CNT_W-1:0]   count;

  assign cfg_ready = 1'b1;

  // Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      potential_scale <= 32'sd65536;
      plane_height    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE:  potential_scale <= cfg_data;
        REG_HEIGHT: plane_height    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .back_idle (back_idle),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .store_wr  (store_wr),
    .count     (count)
  );

  cps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .store_wr (store_wr),
    .count    (count),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .idle     (back_idle),
    .scale    (potential_scale),
    .height   (plane_height),
    .done     (done),
    .result   (result)
  );

`ifndef SYNTHESIS
  // The store is never written while a query may still be reading it.
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    store_wr.we |-> (back_idle && !q_valid))
    else $error("charge store written during a query");

  // The charge count never passes the store size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CHARGES))
    else $error("charge count out of range");

  // A pop only happens while the queue holds a query.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("query queue popped while empty");
`endif

endmodule
